### rtl/core/hash_chain_signature_verify_defines.svh
// assertion helpers for the chain verifier
`ifndef HASH_CHAIN_SIGNATURE_VERIFY_DEFINES_SVH
`define HASH_CHAIN_SIGNATURE_VERIFY_DEFINES_SVH

`define HCSV_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hcsv check failed");

`define HCSV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hcsv check failed");

`endif

### rtl/core/hcsv_pkg.sv
`timescale 1ns / 1ps
package hcsv_pkg;

    localparam int ElemBytes = 32;
    localparam int ChainLen = 16;
    localparam int NumChains = 64;
    localparam int StoreDepth = 4096;
    localparam int AddrW = 12;
    localparam int ElemWords = ElemBytes / 8;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_VERIFY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY,
        ST_RD_PREV,
        ST_AES0,
        ST_AES1,
        ST_RD_WANT,
        ST_CMP,
        ST_OUT
    } state_t;

    // handshake between sequencer and aes core
    typedef struct packed {
        logic start;
        logic [7:0] ctr;
    } aes_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } aes_stat_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] base;
        logic [7:0] prod;
        logic [7:0] aa;
        logic [7:0] bb;
        logic [7:0] e;
        inv = 8'h01;
        base = x;
        e = 8'd254;
        for (int k = 0; k < 8; k++) begin
            if (e[0]) begin
                prod = 8'h00; aa = inv; bb = base;
                for (int j = 0; j < 8; j++) begin
                    if (bb[0]) prod = prod ^ aa;
                    aa = xtime(aa);
                    bb = bb >> 1;
                end
                inv = prod;
            end
            prod = 8'h00; aa = base; bb = base;
            for (int j = 0; j < 8; j++) begin
                if (bb[0]) prod = prod ^ aa;
                aa = xtime(aa);
                bb = bb >> 1;
            end
            base = prod;
            e = e >> 1;
        end
        if (x == 8'h00) inv = 8'h00;
        sbox = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
             ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

### rtl/core/hcsv_aes.sv
`timescale 1ns / 1ps
// iterative aes-256: one round per cycle, round keys expanded on the fly
module hcsv_aes (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [255:0]      key,
    input  hcsv_pkg::aes_req_t req,
    output hcsv_pkg::aes_stat_t stat,
    output logic [127:0]      block
);
    logic [127:0] st_reg, st_next;
    logic [255:0] kw_reg, kw_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [127:0] sb, sr, mc, rk;
    logic [31:0]  t0, w0, w1, w2, w3, u0, u1, u2, u3;

    always_comb begin
        for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = hcsv_pkg::sbox(st_reg[127-8*i -: 8]);
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                sr[127-8*(4*c+i) -: 8] = sb[127-8*(4*((c+i)%4)+i) -: 8];
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3;
            a0 = sr[127-32*c -: 8]; a1 = sr[119-32*c -: 8];
            a2 = sr[111-32*c -: 8]; a3 = sr[103-32*c -: 8];
            mc[127-32*c -: 8] = hcsv_pkg::xtime(a0) ^ hcsv_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
            mc[119-32*c -: 8] = a0 ^ hcsv_pkg::xtime(a1) ^ hcsv_pkg::xtime(a2) ^ a2 ^ a3;
            mc[111-32*c -: 8] = a0 ^ a1 ^ hcsv_pkg::xtime(a2) ^ hcsv_pkg::xtime(a3) ^ a3;
            mc[103-32*c -: 8] = hcsv_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ hcsv_pkg::xtime(a3);
        end
        // kw_reg holds two round keys: odd rounds use the lower half, even the upper
        rk = rnd_reg[0] ? kw_reg[127:0] : kw_reg[255:128];
        // next 8 words, generated every odd round
        t0 = hcsv_pkg::sub_word({kw_reg[23:0], kw_reg[31:24]}) ^ {rcon_reg, 24'h0};
        w0 = kw_reg[255:224] ^ t0;
        w1 = kw_reg[223:192] ^ w0;
        w2 = kw_reg[191:160] ^ w1;
        w3 = kw_reg[159:128] ^ w2;
        u0 = kw_reg[127:96] ^ hcsv_pkg::sub_word(w3);
        u1 = kw_reg[95:64] ^ u0;
        u2 = kw_reg[63:32] ^ u1;
        u3 = kw_reg[31:0] ^ u2;
    end

    always_comb begin
        st_next = st_reg; kw_next = kw_reg; rnd_next = rnd_reg;
        rcon_next = rcon_reg; busy_next = busy_reg; done_next = 1'b0;
        if (req.start) begin
            st_next = {120'h0, req.ctr} ^ key[255:128];
            kw_next = key;
            rnd_next = 4'd1;
            rcon_next = 8'h01;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            st_next = ((rnd_reg == 4'd14) ? sr : mc) ^ rk;
            rnd_next = rnd_reg + 4'd1;
            if (rnd_reg[0]) begin
                kw_next = {w0, w1, w2, w3, u0, u1, u2, u3};
                rcon_next = hcsv_pkg::xtime(rcon_reg);
            end
            if (rnd_reg == 4'd14) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
        kw_reg <= kw_next;
        rnd_reg <= rnd_next;
        rcon_reg <= rcon_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat = '{busy: busy_reg, done: done_reg};
    assign block = st_reg;
endmodule

### rtl/core/hcsv_store.sv
`timescale 1ns / 1ps
module hcsv_store (
    input  logic        aclk,
    input  logic        we,
    input  logic [11:0] waddr,
    input  logic [63:0] wdata,
    input  logic [11:0] raddr,
    output logic [63:0] rdata
);
    logic [63:0] mem [hcsv_pkg::StoreDepth];
    logic [63:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/hash_chain_signature_verify.sv
`timescale 1ns / 1ps
`include "hash_chain_signature_verify_defines.svh"
// Verifies one hash chain of a stored public key per verify item. Write items store one
// 64-bit key word. A verify item reads the element before the digit (4 words, one per
// cycle from the store read port; skipped for digit 0), runs two AES-256 counter blocks
// on a shared one-round-per-cycle core, reads the expected element and compares it.
// The result register frees the input side once the result is taken.
module hash_chain_signature_verify (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action, word_index, word_data, chain_index, digit, key_word0..3, zero fill
    input  logic [343:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // chain_ok, all_ok, zero fill
    output logic [7:0]   m_tdata,
    output logic         m_tlast
);
    hcsv_pkg::state_t state_reg, state_next;
    logic [255:0] key_reg, key_next;
    logic [255:0] pt_reg, pt_next;
    logic [5:0]   chain_reg, chain_next;
    logic [3:0]   digit_reg, digit_next;
    logic         last_reg, last_next;
    logic         act_reg, act_next;
    logic         ok_reg, ok_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         all_reg, all_next;
    logic         mv_reg, mv_next;
    logic [2:0]   mres_reg, mres_next;
    logic [11:0]  waddr_reg, waddr_next;
    logic [63:0]  wdata_reg, wdata_next;
    logic         we;
    logic [11:0]  raddr;
    logic [63:0]  rdata;
    hcsv_pkg::aes_req_t  areq;
    hcsv_pkg::aes_stat_t astat;
    logic [127:0] ablk;
    logic [3:0]   pos;
    logic [1:0]   widx;

    hcsv_store u_store (.aclk(aclk), .we(we), .waddr(waddr_reg), .wdata(wdata_reg),
                        .raddr(raddr), .rdata(rdata));
    hcsv_aes u_aes (.aclk(aclk), .aresetn(aresetn), .key(key_reg), .req(areq),
                    .stat(astat), .block(ablk));

    assign pos = (state_reg == hcsv_pkg::ST_RD_PREV) ? digit_reg - 4'd1 : digit_reg;
    assign widx = cnt_reg[1:0];
    assign raddr = {chain_reg, pos, widx};
    assign s_tready = (state_reg == hcsv_pkg::ST_IDLE) && !mv_reg;

    always_comb begin
        state_next = state_reg; key_next = key_reg; pt_next = pt_reg;
        chain_next = chain_reg; digit_next = digit_reg; last_next = last_reg;
        act_next = act_reg; ok_next = ok_reg; cnt_next = cnt_reg; all_next = all_reg;
        mv_next = mv_reg; mres_next = mres_reg; waddr_next = waddr_reg;
        wdata_next = wdata_reg; we = 1'b0; areq = '{start: 1'b0, ctr: 8'h00};
        if (mv_reg && m_tready) mv_next = 1'b0;
        case (state_reg)
            hcsv_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    act_next = s_tdata[0];
                    waddr_next = s_tdata[12:1];
                    wdata_next = s_tdata[76:13];
                    chain_next = s_tdata[82:77];
                    digit_next = s_tdata[86:83];
                    key_next = {s_tdata[150:87], s_tdata[214:151],
                                s_tdata[278:215], s_tdata[342:279]};
                    last_next = s_tlast;
                    cnt_next = 3'd0;
                    pt_next = '0;
                    state_next = hcsv_pkg::ST_KEY;
                end
            end
            hcsv_pkg::ST_KEY: begin
                if (act_reg == hcsv_pkg::ACT_WRITE) begin
                    we = 1'b1;
                    ok_next = 1'b1;
                    state_next = hcsv_pkg::ST_OUT;
                end else if (digit_reg == 4'd0) begin
                    areq = '{start: 1'b1, ctr: 8'h00};
                    state_next = hcsv_pkg::ST_AES0;
                end else begin
                    state_next = hcsv_pkg::ST_RD_PREV;
                end
            end
            hcsv_pkg::ST_RD_PREV: begin
                // read issued at cnt, data lands in the following cycle
                if (cnt_reg != 3'd0)
                    pt_next[255-64*(cnt_reg-3'd1) -: 64] = rdata;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    cnt_next = 3'd0;
                    areq = '{start: 1'b1, ctr: 8'h00};
                    state_next = hcsv_pkg::ST_AES0;
                end
            end
            hcsv_pkg::ST_AES0: begin
                if (astat.done) begin
                    pt_next[255:128] = pt_reg[255:128] ^ ablk;
                    areq = '{start: 1'b1, ctr: 8'h01};
                    state_next = hcsv_pkg::ST_AES1;
                end
            end
            hcsv_pkg::ST_AES1: begin
                if (astat.done) begin
                    pt_next[127:0] = pt_reg[127:0] ^ ablk;
                    ok_next = 1'b1;
                    cnt_next = 3'd0;
                    state_next = hcsv_pkg::ST_RD_WANT;
                end
            end
            hcsv_pkg::ST_RD_WANT: begin
                if (cnt_reg != 3'd0 && pt_reg[255-64*(cnt_reg-3'd1) -: 64] != rdata)
                    ok_next = 1'b0;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) state_next = hcsv_pkg::ST_CMP;
            end
            hcsv_pkg::ST_CMP: begin
                all_next = all_reg & ok_reg;
                state_next = hcsv_pkg::ST_OUT;
            end
            hcsv_pkg::ST_OUT: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    if (act_reg == hcsv_pkg::ACT_WRITE) begin
                        mres_next = {1'b0, all_reg, 1'b1};
                    end else begin
                        mres_next = {last_reg, all_reg, ok_reg};
                        if (last_reg) all_next = 1'b1;
                    end
                    state_next = hcsv_pkg::ST_IDLE;
                end
            end
            default: state_next = hcsv_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next; pt_reg <= pt_next; chain_reg <= chain_next;
        digit_reg <= digit_next; last_reg <= last_next; act_reg <= act_next;
        ok_reg <= ok_next; cnt_reg <= cnt_next; mres_reg <= mres_next;
        waddr_reg <= waddr_next; wdata_reg <= wdata_next;
        if (!aresetn) begin
            state_reg <= hcsv_pkg::ST_IDLE;
            all_reg <= 1'b1;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            all_reg <= all_next;
            mv_reg <= mv_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = {6'b0, mres_reg[1:0]};
    assign m_tlast = mres_reg[2];

    `HCSV_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != hcsv_pkg::ST_IDLE,
        !s_tready)
    `HCSV_ASSERT_IMPL(a_aes_done_ends, aclk, aresetn, astat.done, !astat.busy)
    `HCSV_ASSERT_IMPL(a_write_ok, aclk, aresetn, m_tvalid && !m_tlast && !act_reg,
        m_tdata[0])
endmodule

### tb/sv/tb_hash_chain_signature_verify.sv
`timescale 1ns / 1ps
module tb_hash_chain_signature_verify;

    typedef struct {
        logic         act;
        logic [11:0]  widx;
        logic [63:0]  wdata;
        logic [5:0]   chain;
        logic [3:0]   digit;
        logic [255:0] key;
        logic         last;
    } chain_item_t;

    typedef struct {
        chain_item_t it;
        bit          typed;
        logic [2:0]  res;   // {is_done, all_ok, chain_ok}
    } table_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [343:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic         m_tlast;

    logic [63:0]  pk_mem [hcsv_pkg::StoreDepth];
    bit           pk_written [hcsv_pkg::StoreDepth];
    logic         pass_acc;
    logic [7:0]   sbox_tab [256];
    logic [2:0]   verdicts [$];
    table_row_t   rows [$];
    int           errors;
    int           sent;
    bit           quiet;

    hash_chain_signature_verify i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return r;
    endfunction

    // two counter blocks of aes-256 under the signature element as key
    function automatic logic [255:0] ctr_stream(input logic [255:0] key);
        logic [7:0]   rk [240];
        logic [7:0]   t [4];
        logic [7:0]   s [16];
        logic [7:0]   u [16];
        logic [7:0]   rcon;
        logic [7:0]   f;
        logic [255:0] ks;
        rcon = 8'h01;
        for (int i = 0; i < 32; i++) rk[i] = key[255 - 8 * i -: 8];
        for (int i = 8; i < 60; i++) begin
            for (int j = 0; j < 4; j++) t[j] = rk[4 * (i - 1) + j];
            if (i % 8 == 0) begin
                f = t[0];
                t[0] = sbox_tab[t[1]] ^ rcon;
                t[1] = sbox_tab[t[2]];
                t[2] = sbox_tab[t[3]];
                t[3] = sbox_tab[f];
                rcon = gmul(rcon, 8'h02);
            end else if (i % 8 == 4) begin
                for (int j = 0; j < 4; j++) t[j] = sbox_tab[t[j]];
            end
            for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - 8) + j] ^ t[j];
        end
        for (int blk = 0; blk < 2; blk++) begin
            for (int i = 0; i < 16; i++) s[i] = rk[i];
            s[15] = s[15] ^ 8'(blk);
            for (int r = 1; r <= 14; r++) begin
                for (int i = 0; i < 16; i++) s[i] = sbox_tab[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++) u[4 * c + i] = s[4 * ((c + i) % 4) + i];
                for (int c = 0; c < 4; c++) begin
                    if (r != 14) begin
                        s[4 * c]     = gmul(u[4 * c], 8'h02) ^ gmul(u[4 * c + 1], 8'h03)
                                     ^ u[4 * c + 2] ^ u[4 * c + 3];
                        s[4 * c + 1] = u[4 * c] ^ gmul(u[4 * c + 1], 8'h02)
                                     ^ gmul(u[4 * c + 2], 8'h03) ^ u[4 * c + 3];
                        s[4 * c + 2] = u[4 * c] ^ u[4 * c + 1]
                                     ^ gmul(u[4 * c + 2], 8'h02) ^ gmul(u[4 * c + 3], 8'h03);
                        s[4 * c + 3] = gmul(u[4 * c], 8'h03) ^ u[4 * c + 1]
                                     ^ u[4 * c + 2] ^ gmul(u[4 * c + 3], 8'h02);
                    end else begin
                        for (int i = 0; i < 4; i++) s[4 * c + i] = u[4 * c + i];
                    end
                end
                for (int i = 0; i < 16; i++) s[i] ^= rk[16 * r + i];
            end
            for (int i = 0; i < 16; i++) ks[255 - 8 * (16 * blk + i) -: 8] = s[i];
        end
        return ks;
    endfunction

    function automatic int elem_base(input int c, input int p);
        return (c * hcsv_pkg::ChainLen + p) * hcsv_pkg::ElemWords;
    endfunction

    function automatic logic [255:0] elem_of(input int c, input int p);
        int a;
        a = elem_base(c, p);
        return {pk_mem[a], pk_mem[a + 1], pk_mem[a + 2], pk_mem[a + 3]};
    endfunction

    function automatic bit elem_known(input int c, input int p);
        int a;
        a = elem_base(c, p);
        return pk_written[a] && pk_written[a + 1] && pk_written[a + 2] && pk_written[a + 3];
    endfunction

    // element that a correct chain step from position p-1 produces under key
    function automatic logic [255:0] next_elem(input int c, input int p,
                                               input logic [255:0] key);
        return (p == 0 ? 256'd0 : elem_of(c, p - 1)) ^ ctr_stream(key);
    endfunction

    function automatic logic [2:0] predict_verdict(input chain_item_t it);
        logic ok;
        if (it.act == hcsv_pkg::ACT_WRITE) begin
            pk_mem[it.widx] = it.wdata;
            pk_written[it.widx] = 1'b1;
            return {1'b0, pass_acc, 1'b1};
        end
        ok = (next_elem(int'(it.chain), int'(it.digit), it.key)
              == elem_of(int'(it.chain), int'(it.digit)));
        pass_acc = pass_acc & ok;
        predict_verdict = {it.last, pass_acc, ok};
        if (it.last) pass_acc = 1'b1;
    endfunction

    task automatic send_item(input chain_item_t it, input bit typed, input logic [2:0] res);
        logic [2:0] p;
        if (!quiet && $urandom_range(3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tdata = {1'b0, it.key[63:0], it.key[127:64], it.key[191:128], it.key[255:192],
                   it.digit, it.chain, it.wdata, it.widx, it.act};
        s_tlast = it.last;
        s_tvalid = 1'b1;
        // s_tready depends only on registered state, so its value at the falling edge holds at the next rise
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        p = predict_verdict(it);
        verdicts.push_back(typed ? res : p);
        sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    function automatic chain_item_t rand_item();
        chain_item_t it;
        it.act = hcsv_pkg::ACT_WRITE;
        it.widx = 12'($urandom);
        it.wdata = {$urandom, $urandom};
        it.chain = 6'($urandom);
        it.digit = 4'($urandom);
        it.key = {$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
        it.last = 1'($urandom);
        return it;
    endfunction

    task automatic write_elem(input int c, input int p, input logic [255:0] v);
        chain_item_t it;
        for (int k = 0; k < hcsv_pkg::ElemWords; k++) begin
            it = rand_item();
            it.widx = 12'(elem_base(c, p) + k);
            it.wdata = v[255 - 64 * k -: 64];
            send_item(it, 1'b0, 3'b000);
        end
    endtask

    // a well-formed chain step, sometimes with a broken element or key
    task automatic chain_step();
        chain_item_t it;
        logic [255:0] good;
        int c;
        int p;
        int mode;
        it = rand_item();
        it.act = hcsv_pkg::ACT_VERIFY;
        c = int'(it.chain);
        p = int'(it.digit);
        it.last = ($urandom_range(3) == 0);
        if (p > 0 && (!elem_known(c, p - 1) || $urandom_range(3) == 0))
            write_elem(c, p - 1, it.key ^ {$urandom, $urandom, 192'd0});
        good = next_elem(c, p, it.key);
        mode = int'($urandom_range(15));
        if (mode < 12 || !elem_known(c, p))
            write_elem(c, p, mode == 13 ? good ^ (256'd1 << $urandom_range(255)) : good);
        if (mode == 14) it.key[$urandom_range(255)] ^= 1'b1;
        send_item(it, 1'b0, 3'b000);
    endtask

    task automatic add_row(input logic act, input int widx, input logic [63:0] wdata,
                           input int c, input int d, input logic [255:0] key,
                           input logic last, input bit typed, input logic [2:0] res);
        table_row_t r;
        r.it.act = act;
        r.it.widx = 12'(widx);
        r.it.wdata = wdata;
        r.it.chain = 6'(c);
        r.it.digit = 4'(d);
        r.it.key = key;
        r.it.last = last;
        r.typed = typed;
        r.res = res;
        rows.push_back(r);
    endtask

    // result checker
    always @(posedge aclk) begin
        logic [2:0] want;
        logic [2:0] got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tlast, m_tdata[1:0]};
            if (verdicts.size() == 0) begin
                report($sformatf("result %b with nothing expected", got));
            end else begin
                want = verdicts.pop_front();
                if (got[0] !== want[0]) report($sformatf("chain_ok %b want %b", got[0], want[0]));
                if (got[1] !== want[1]) report($sformatf("all_ok %b want %b", got[1], want[1]));
                if (got[2] !== want[2]) report($sformatf("is_done %b want %b", got[2], want[2]));
                if (m_tdata[7:2] !== 6'd0) report("nonzero fill bits in m_tdata");
            end
        end
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready = quiet || ($urandom_range(3) != 0);
            repeat ($urandom_range(1, 16) - 1) @(negedge aclk);
        end
    end

    initial begin
        logic [255:0] ones;
        errors = 0;
        sent = 0;
        quiet = 1'b0;
        pass_acc = 1'b1;
        ones = '1;
        for (int x = 0; x < 256; x++) begin
            logic [7:0] inv;
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
            sbox_tab[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
        for (int a = 0; a < hcsv_pkg::StoreDepth; a++) begin
            pk_mem[a] = 64'd0;
            pk_written[a] = 1'b0;
        end
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // chain 0 element 0 all zero: keystream never matches, sticky pass drops then re-arms
        for (int k = 0; k < 4; k++)
            add_row(hcsv_pkg::ACT_WRITE, k, 64'd0, 0, 0, 256'd0, 1'b1, 1'b1, 3'b011);
        add_row(hcsv_pkg::ACT_VERIFY, 0, 64'd0, 0, 0, 256'd0, 1'b0, 1'b1, 3'b000);
        add_row(hcsv_pkg::ACT_WRITE, 4095, '1, 0, 0, ones, 1'b0, 1'b1, 3'b001);
        add_row(hcsv_pkg::ACT_VERIFY, 0, '1, 0, 0, ones, 1'b1, 1'b1, 3'b100);
        add_row(hcsv_pkg::ACT_WRITE, 2048, 64'h8000_0000_0000_0001, 0, 0, 256'd0, 1'b0,
                1'b1, 3'b011);
        // last chain, last digit, extreme keys
        for (int k = 0; k < 8; k++)
            add_row(hcsv_pkg::ACT_WRITE, elem_base(63, 14) + k, {$urandom, $urandom}, 0, 0,
                    256'd0, 1'b0, 1'b1, 3'b011);
        add_row(hcsv_pkg::ACT_VERIFY, 0, 64'd0, 63, 15, ones, 1'b0, 1'b0, 3'b000);
        add_row(hcsv_pkg::ACT_VERIFY, 0, 64'd0, 63, 15, 256'd0, 1'b1, 1'b0, 3'b000);
        add_row(hcsv_pkg::ACT_VERIFY, 0, 64'd0, 0, 0, ones, 1'b1, 1'b1, 3'b100);
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);
        // matching steps at the corners
        begin
            chain_item_t it;
            it = rand_item();
            it.act = hcsv_pkg::ACT_VERIFY;
            it.chain = 6'd63;
            it.digit = 4'd15;
            it.key = ones;
            it.last = 1'b1;
            write_elem(63, 15, next_elem(63, 15, ones));
            send_item(it, 1'b0, 3'b000);
            it.chain = 6'd0;
            it.digit = 4'd0;
            it.key = 256'd0;
            write_elem(0, 0, next_elem(0, 0, 256'd0));
            send_item(it, 1'b0, 3'b000);
        end

        while (sent < 1800) begin
            if (sent > 1600) quiet = 1'b1;
            if ($urandom_range(6) == 0) send_item(rand_item(), 1'b0, 3'b000);
            else chain_step();
        end

        while (verdicts.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
